### rtl/pbsa_pkg.sv
package pbsa_pkg;

	localparam logic [1:0] OP_ALLOC = 2'd0;
	localparam logic [1:0] OP_FREE  = 2'd1;
	localparam logic [1:0] OP_CLEAR = 2'd2;

	localparam logic [1:0] STS_OK    = 2'd0;
	localparam logic [1:0] STS_FULL  = 2'd1;
	localparam logic [1:0] STS_RANGE = 2'd2;

	localparam int OP_W      = 2;
	localparam int IDX_W     = 11;
	localparam int GRANT_W   = 10;
	localparam int OFF_W     = 18;
	localparam int STS_W     = 2;
	localparam int SB_W      = 13;
	localparam logic [SB_W-1:0] SLOT_BYTES_RST = 13'd16;
	localparam logic [OFF_W:0]  OFF_MAX = 19'h3FFFF;

	typedef struct packed {
		logic [OP_W-1:0]  op;
		logic [IDX_W-1:0] slot_index;
	} in_word_t;

	typedef struct packed {
		logic [GRANT_W-1:0] granted_slot;
		logic [OFF_W-1:0]   byte_offset;
		logic [STS_W-1:0]   status;
	} out_word_t;

	typedef struct packed {
		logic capture;
		logic search;
		logic modify;
		logic load_out;
	} cmd_t;

	typedef struct packed {
		logic out_full;
	} sts_t;

endpackage

### rtl/pbsa_ctrl.sv
module pbsa_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  pbsa_pkg::sts_t sts,
	output pbsa_pkg::cmd_t cmd
);
	import pbsa_pkg::*;

	localparam logic [1:0] S_IDLE   = 2'd0;
	localparam logic [1:0] S_SEARCH = 2'd1;
	localparam logic [1:0] S_MODIFY = 2'd2;
	localparam logic [1:0] S_DONE   = 2'd3;

	logic [1:0] state_q;
	logic [1:0] state_d;
	logic       accept;

	assign in_ready = (state_q == S_IDLE) || ((state_q == S_DONE) && !sts.out_full);
	assign accept   = in_valid && in_ready;

	always_comb begin
		state_d      = state_q;
		cmd.capture  = accept;
		cmd.search   = 1'b0;
		cmd.modify   = 1'b0;
		cmd.load_out = 1'b0;
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					state_d = S_SEARCH;
				end
			end
			S_SEARCH: begin
				cmd.search = 1'b1;
				state_d    = S_MODIFY;
			end
			S_MODIFY: begin
				cmd.modify = 1'b1;
				state_d    = S_DONE;
			end
			S_DONE: begin
				if (!sts.out_full) begin
					cmd.load_out = 1'b1;
					state_d      = accept ? S_SEARCH : S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

### rtl/pbsa_dp.sv
module pbsa_dp #(
	parameter int SLOTS_PER_PAGE = 64,
	parameter int PAGE_COUNT     = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  pbsa_pkg::cmd_t                cmd,
	output pbsa_pkg::sts_t                sts,
	input  pbsa_pkg::in_word_t            in_data,
	input  logic [pbsa_pkg::SB_W-1:0]     slot_bytes,
	output logic                          out_valid,
	input  logic                          out_ready,
	output pbsa_pkg::out_word_t           out_data
);
	import pbsa_pkg::*;

	localparam int SLOT_W  = $clog2(SLOTS_PER_PAGE);
	localparam int PAGE_W  = (PAGE_COUNT > 1) ? $clog2(PAGE_COUNT) : 1;
	localparam int TOTAL   = PAGE_COUNT * SLOTS_PER_PAGE;
	localparam int RCP_SH  = 16;
	localparam int RCP     = (1 << RCP_SH) / SLOTS_PER_PAGE;
	localparam int RCP_W   = RCP_SH + 1;
	localparam int PROD_W  = IDX_W + RCP_W;
	localparam int Q_W     = IDX_W;
	localparam int BASE_W  = 16;
	localparam int MUL_W   = OFF_W + 1;

	logic [SLOTS_PER_PAGE-1:0] mem [PAGE_COUNT];
	logic [PAGE_COUNT-1:0]     page_vld_q;
	logic [PAGE_COUNT-1:0]     nonfull_q;

	logic [OP_W-1:0]  op_q;
	logic [IDX_W-1:0] idx_q;
	logic [Q_W-1:0]   qest_q;
	logic             range_q;
	logic [PROD_W-1:0] rcp_prod;

	logic [PAGE_W-1:0] pf;
	logic              any_free;
	logic [Q_W-1:0]    q_fix;
	logic [IDX_W-1:0]  rem_raw;
	logic [IDX_W-1:0]  rem_fix;
	logic [PAGE_W-1:0] rd_addr;

	logic [SLOTS_PER_PAGE-1:0] rd_word_s2;
	logic                      rd_vld_s2;
	logic [PAGE_W-1:0]         page_s2;
	logic [SLOT_W-1:0]         elem_s2;
	logic [BASE_W-1:0]         base_s2;
	logic                      hit_s2;

	logic [SLOTS_PER_PAGE-1:0] word;
	logic [SLOT_W-1:0]         ea;
	logic [SLOTS_PER_PAGE-1:0] new_alloc;
	logic [SLOTS_PER_PAGE-1:0] new_free;
	logic [SLOTS_PER_PAGE-1:0] new_word;
	logic                      do_write;
	logic [MUL_W-1:0]          off_prod;
	logic [BASE_W-1:0]         grant_full;
	out_word_t                 res_d;
	out_word_t                 res_s3;

	logic      out_valid_q;
	out_word_t out_data_q;

	assign rcp_prod = PROD_W'(in_data.slot_index) * PROD_W'(RCP);

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			op_q    <= in_data.op;
			idx_q   <= in_data.slot_index;
			qest_q  <= rcp_prod[RCP_SH +: Q_W];
			range_q <= (int'(in_data.slot_index) < TOTAL);
		end
	end

	always_comb begin
		pf = '0;
		for (int p = PAGE_COUNT - 1; p >= 0; p--) begin
			if (nonfull_q[p]) begin
				pf = PAGE_W'(p);
			end
		end
	end

	assign any_free = |nonfull_q;
	assign rem_raw  = IDX_W'(idx_q - IDX_W'(qest_q * IDX_W'(SLOTS_PER_PAGE)));

	always_comb begin
		if (rem_raw >= IDX_W'(SLOTS_PER_PAGE)) begin
			q_fix   = qest_q + 1'b1;
			rem_fix = rem_raw - IDX_W'(SLOTS_PER_PAGE);
		end else begin
			q_fix   = qest_q;
			rem_fix = rem_raw;
		end
	end

	assign rd_addr = (op_q == OP_ALLOC) ? pf : q_fix[PAGE_W-1:0];

	always_ff @(posedge clk) begin
		if (cmd.search) begin
			rd_word_s2 <= mem[rd_addr];
			page_s2    <= rd_addr;
		end
		if (cmd.modify && do_write) begin
			mem[page_s2] <= new_word;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.search) begin
			rd_vld_s2 <= page_vld_q[rd_addr];
			elem_s2   <= rem_fix[SLOT_W-1:0];
			base_s2   <= BASE_W'(pf) * BASE_W'(SLOTS_PER_PAGE);
			hit_s2    <= any_free;
		end
	end

	assign word = rd_vld_s2 ? rd_word_s2 : '1;

	always_comb begin
		ea = '0;
		for (int e = SLOTS_PER_PAGE - 1; e >= 0; e--) begin
			if (word[e]) begin
				ea = SLOT_W'(e);
			end
		end
	end

	assign new_alloc = word & ~(SLOTS_PER_PAGE'(1) << ea);
	assign new_free  = word | (SLOTS_PER_PAGE'(1) << elem_s2);
	assign new_word  = (op_q == OP_ALLOC) ? new_alloc : new_free;
	assign do_write  = ((op_q == OP_ALLOC) && hit_s2) || ((op_q == OP_FREE) && range_q);
	assign off_prod  = MUL_W'(ea) * MUL_W'(slot_bytes);
	assign grant_full = base_s2 + BASE_W'(ea);

	always_comb begin
		res_d = '0;
		case (op_q)
			OP_ALLOC: begin
				if (hit_s2) begin
					res_d.granted_slot = grant_full[GRANT_W-1:0];
					res_d.byte_offset  = (off_prod > OFF_MAX) ? OFF_MAX[OFF_W-1:0]
					                                          : off_prod[OFF_W-1:0];
					res_d.status       = STS_OK;
				end else begin
					res_d.status = STS_FULL;
				end
			end
			OP_FREE: begin
				res_d.status = range_q ? STS_OK : STS_RANGE;
			end
			default: begin
				res_d = '0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.modify) begin
			res_s3 <= res_d;
		end
		if (cmd.load_out) begin
			out_data_q <= res_s3;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			page_vld_q  <= '0;
			nonfull_q   <= '1;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.search && (op_q == OP_CLEAR)) begin
				page_vld_q <= '0;
				nonfull_q  <= '1;
			end
			if (cmd.modify && do_write) begin
				page_vld_q[page_s2] <= 1'b1;
				nonfull_q[page_s2]  <= (op_q == OP_ALLOC) ? (|new_alloc) : 1'b1;
			end
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign sts.out_full = out_valid_q && !out_ready;
	assign out_valid    = out_valid_q;
	assign out_data     = out_data_q;

endmodule

### rtl/paged_bitmap_slot_allocator_core.sv
// Paged bitmap slot allocator.
// The pool holds PAGE_COUNT pages of SLOTS_PER_PAGE slots. Each input word on
// the in channel (valid/ready) carries an operation: allocate the lowest free
// slot, free one slot by global index, or free every slot. Each input word
// produces exactly one result word on the out channel (valid/ready) with the
// granted slot, its byte offset in the page and a status code.
// The slot_bytes register is written through cfg_wen and cfg_wdata and only
// scales the byte offset; the user must write it only while the block is idle,
// and the block itself does not enforce this. One word is processed at a time:
// a search over the per-page summary bits, then a read-modify-write of one page
// mask in the page memory, then the result enters the output register. A new
// word is accepted in the cycle the previous result is loaded.
// When the receiver stalls, the result holds in the output register and the
// next word is still taken; it waits after its memory update until the output
// register drains. Reset frees every slot at once through per-page valid bits
// and sets slot_bytes to 16; no clearing pass is needed.
module paged_bitmap_slot_allocator_core #(
	parameter int SLOTS_PER_PAGE = 64,
	parameter int PAGE_COUNT     = 16
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_ready,
	input  pbsa_pkg::in_word_t        in_data,
	output logic                      out_valid,
	input  logic                      out_ready,
	output pbsa_pkg::out_word_t       out_data,
	input  logic                      cfg_wen,
	input  logic [pbsa_pkg::SB_W-1:0] cfg_wdata
);
	import pbsa_pkg::*;

	logic [SB_W-1:0] slot_bytes_q;
	cmd_t            cmd;
	sts_t            sts;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_bytes_q <= SLOT_BYTES_RST;
		end else if (cfg_wen) begin
			slot_bytes_q <= cfg_wdata;
		end
	end

	pbsa_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	pbsa_dp #(
		.SLOTS_PER_PAGE (SLOTS_PER_PAGE),
		.PAGE_COUNT     (PAGE_COUNT)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.sts        (sts),
		.in_data    (in_data),
		.slot_bytes (slot_bytes_q),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.out_data   (out_data)
	);

endmodule

### rtl/pbsa_checker.sv
module pbsa_checker (
	input logic                      clk,
	input logic                      arst_n,
	input logic                      in_valid,
	input logic                      in_ready,
	input logic                      out_valid,
	input logic                      out_ready,
	input pbsa_pkg::out_word_t       out_data
);
	import pbsa_pkg::*;

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("Result word changed while stalled.");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("Input accepted on two consecutive cycles.");

	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (out_data.status == STS_FULL || out_data.status == STS_RANGE)
		|-> out_data.granted_slot == '0 && out_data.byte_offset == '0)
		else $error("Error result carries a slot or offset.");

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (out_data.status == STS_OK || out_data.status == STS_FULL
		               || out_data.status == STS_RANGE))
		else $error("Result status code is undefined.");

	a_offset_ok: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.byte_offset != '0 |-> out_data.status == STS_OK)
		else $error("Nonzero offset on a failed result.");

endmodule

bind paged_bitmap_slot_allocator_core pbsa_checker u_pbsa_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_ready  (in_ready),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.out_data  (out_data)
);

### tb/sv/tb_paged_bitmap_slot_allocator_core.sv
`timescale 1ns / 1ps

module tb_paged_bitmap_slot_allocator_core;
	import pbsa_pkg::*;

	localparam int SLOTS = 64;
	localparam int PAGES = 16;
	localparam int POOL_SLOTS = SLOTS * PAGES;
	localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int REPORT_LIMIT = 10;

	logic clk;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	in_word_t in_data = '0;
	logic out_valid;
	logic out_ready = 1'b1;
	out_word_t out_data;
	logic cfg_wen = 1'b0;
	logic [SB_W-1:0] cfg_wdata = '0;

	logic [SLOTS-1:0] pool_free_mask [PAGES];
	logic [SB_W-1:0] pool_slot_bytes;
	out_word_t pending_results [$];
	int live_slots [$];
	int error_count = 0;
	bit steady = 1'b0;

	paged_bitmap_slot_allocator_core #(
		.SLOTS_PER_PAGE(SLOTS),
		.PAGE_COUNT(PAGES)
	) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data(out_data),
		.cfg_wen(cfg_wen),
		.cfg_wdata(cfg_wdata)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	function automatic void reset_pool();
		for (int p = 0; p < PAGES; p++) begin
			pool_free_mask[p] = '1;
		end
	endfunction

	function automatic out_word_t predict_result(input in_word_t w);
		out_word_t r;
		bit found;
		int unsigned prod;
		int idx;
		r = '0;
		found = 1'b0;
		idx = int'(w.slot_index);
		case (w.op)
			OP_ALLOC: begin
				for (int p = 0; p < PAGES && !found; p++) begin
					for (int e = 0; e < SLOTS && !found; e++) begin
						if (pool_free_mask[p][e]) begin
							pool_free_mask[p][e] = 1'b0;
							r.granted_slot = GRANT_W'(p * SLOTS + e);
							prod = unsigned'(e * int'(pool_slot_bytes));
							r.byte_offset = (prod > OFF_MAX) ? '1 : OFF_W'(prod);
							found = 1'b1;
						end
					end
				end
				if (!found) begin
					r.status = STS_FULL;
				end
			end
			OP_FREE: begin
				if (idx >= POOL_SLOTS) begin
					r.status = STS_RANGE;
				end else begin
					pool_free_mask[idx / SLOTS][idx % SLOTS] = 1'b1;
				end
			end
			OP_CLEAR: begin
				reset_pool();
			end
			default: begin
			end
		endcase
		return r;
	endfunction

	function automatic int draw_wait();
		if (steady || $urandom_range(0, 3) == 0) begin
			return 0;
		end
		return int'($urandom_range(0, 16));
	endfunction

	task automatic flag_mismatch(input string what, input longint want, input longint got);
		error_count++;
		if (error_count <= REPORT_LIMIT) begin
			$display("mismatch %s: expected %0d, actual %0d", what, want, got);
		end
	endtask

	task automatic check_result(input out_word_t got);
		out_word_t want;
		if (pending_results.size() == 0) begin
			flag_mismatch("word with nothing pending", longint'(0), longint'(got));
		end else begin
			want = pending_results.pop_front();
			if (got.granted_slot !== want.granted_slot) begin
				flag_mismatch("granted_slot", longint'(want.granted_slot),
				              longint'(got.granted_slot));
			end
			if (got.byte_offset !== want.byte_offset) begin
				flag_mismatch("byte_offset", longint'(want.byte_offset),
				              longint'(got.byte_offset));
			end
			if (got.status !== want.status) begin
				flag_mismatch("status", longint'(want.status), longint'(got.status));
			end
		end
	endtask

	task automatic send_word(input in_word_t w);
		int gap;
		out_word_t want;
		int hits [$];
		gap = draw_wait();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= w;
		do @(posedge clk); while (!in_ready);
		want = predict_result(w);
		pending_results = {pending_results, want};
		if (w.op == OP_ALLOC && want.status == STS_OK) begin
			live_slots = {live_slots, int'(want.granted_slot)};
		end else if (w.op == OP_FREE && want.status == STS_OK) begin
			hits = live_slots.find_first_index(s) with (s == int'(w.slot_index));
			if (hits.size() != 0) begin
				live_slots.delete(hits[0]);
			end
		end else if (w.op == OP_CLEAR) begin
			live_slots.delete();
		end
	endtask

	task automatic send_op(input logic [OP_W-1:0] op, input int idx);
		in_word_t w;
		w.op = op;
		w.slot_index = IDX_W'(idx);
		send_word(w);
	endtask

	task automatic wait_idle();
		in_valid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_slot_bytes(input logic [SB_W-1:0] value);
		wait_idle();
		cfg_wen <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_wen <= 1'b0;
		pool_slot_bytes = value;
	endtask

	function automatic in_word_t random_word();
		in_word_t w;
		int pick;
		w.op = OP_ALLOC;
		w.slot_index = IDX_W'($urandom);
		pick = int'($urandom_range(0, 99));
		if (pick < 50) begin
			w.op = OP_ALLOC;
		end else if (pick < 80 && live_slots.size() != 0) begin
			w.op = OP_FREE;
			w.slot_index = IDX_W'(live_slots[$urandom_range(0, live_slots.size() - 1)]);
		end else if (pick < 90) begin
			w.op = OP_FREE;
			w.slot_index = IDX_W'($urandom_range(0, POOL_SLOTS - 1));
		end else if (pick < 94) begin
			w.op = OP_FREE;
		end else if (pick < 97) begin
			w.op = OP_UNUSED;
		end else begin
			w.op = OP_CLEAR;
		end
		return w;
	endfunction

	task automatic test_basic_ops();
		send_op(OP_ALLOC, 0);
		send_op(OP_ALLOC, 2047);
		send_op(OP_ALLOC, 1365);
		send_op(OP_FREE, 1);
		send_op(OP_ALLOC, 0);
		send_op(OP_FREE, 5);
		send_op(OP_FREE, POOL_SLOTS - 1);
		send_op(OP_FREE, POOL_SLOTS);
		send_op(OP_FREE, 2047);
		send_op(OP_UNUSED, 2047);
		send_op(OP_UNUSED, 0);
		send_op(OP_CLEAR, 2047);
		send_op(OP_ALLOC, 682);
		send_op(OP_FREE, 0);
		send_op(OP_ALLOC, 0);
		send_op(OP_ALLOC, 0);
	endtask

	task automatic test_pool_full();
		write_slot_bytes(13'h1FFF);
		send_op(OP_CLEAR, 0);
		for (int i = 0; i < POOL_SLOTS + 2; i++) begin
			send_op(OP_ALLOC, int'($urandom_range(0, 2047)));
		end
		send_op(OP_FREE, 700);
		send_op(OP_FREE, 63);
		send_op(OP_ALLOC, 0);
		send_op(OP_ALLOC, 0);
		send_op(OP_ALLOC, 0);
	endtask

	task automatic test_random_mix();
		logic [SB_W-1:0] settings [6];
		settings[0] = 13'd1;
		settings[1] = 13'd4096;
		settings[2] = 13'd0;
		settings[3] = 13'd16;
		settings[4] = 13'h1FFF;
		settings[5] = SB_W'($urandom_range(1, 4096));
		for (int ph = 0; ph < 6; ph++) begin
			write_slot_bytes(settings[ph]);
			steady = (ph == 3);
			for (int i = 0; i < 50; i++) begin
				send_word(random_word());
			end
		end
		steady = 1'b0;
	endtask

	initial begin : result_monitor
		int hold;
		hold = 0;
		forever begin
			@(posedge clk);
			if (out_valid && out_ready) begin
				check_result(out_data);
				hold = draw_wait();
				if (hold > 0) begin
					out_ready <= 1'b0;
				end
			end else if (!out_ready) begin
				if (hold > 0) begin
					hold--;
				end
				if (hold == 0) begin
					out_ready <= 1'b1;
				end
			end
		end
	end

	initial begin : watchdog
		int idle;
		idle = 0;
		forever begin
			@(posedge clk);
			if ((in_valid && in_ready) || (out_valid && out_ready)) begin
				idle = 0;
			end else begin
				idle++;
			end
			if (idle >= WATCHDOG_LIMIT) begin
				$display("DONE: errors detected");
				$finish;
			end
		end
	end

	initial begin
		reset_pool();
		pool_slot_bytes = SLOT_BYTES_RST;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_basic_ops();
		test_pool_full();
		test_random_mix();
		wait_idle();
		repeat (8) @(posedge clk);
		if (error_count == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

endmodule

### files.f
rtl/pbsa_pkg.sv
rtl/pbsa_ctrl.sv
rtl/pbsa_dp.sv
rtl/paged_bitmap_slot_allocator_core.sv
rtl/pbsa_checker.sv
tb/sv/tb_paged_bitmap_slot_allocator_core.sv
